// ===== sv/mbsp_pkg.sv =====
// Shared types, codes and decode helpers for the MIDI byte stream parser.
// No dependencies; every other file uses this package.
package mbsp_pkg;

	localparam int KIND_W = 5;
	localparam int CHAN_W = 4;
	localparam int BYTE_W = 8;
	localparam int BEND_W = 15;

	// event kinds
	localparam logic [KIND_W-1:0] KIND_PITCH_BEND   = 5'd6;
	localparam logic [KIND_W-1:0] KIND_SYSEX_START  = 5'd7;
	localparam logic [KIND_W-1:0] KIND_SYSEX_DATA   = 5'd8;
	localparam logic [KIND_W-1:0] KIND_SYSEX_END    = 5'd9;
	localparam logic [KIND_W-1:0] KIND_QUARTER      = 5'd10;
	localparam logic [KIND_W-1:0] KIND_SONG_POS     = 5'd11;
	localparam logic [KIND_W-1:0] KIND_SONG_SEL     = 5'd12;
	localparam logic [KIND_W-1:0] KIND_TUNE_REQ     = 5'd13;
	localparam logic [KIND_W-1:0] KIND_CLOCK        = 5'd14;
	localparam logic [KIND_W-1:0] KIND_START        = 5'd15;
	localparam logic [KIND_W-1:0] KIND_CONTINUE     = 5'd16;
	localparam logic [KIND_W-1:0] KIND_STOP         = 5'd17;
	localparam logic [KIND_W-1:0] KIND_SENSE        = 5'd18;
	localparam logic [KIND_W-1:0] KIND_RESET        = 5'd19;
	localparam logic [KIND_W-1:0] KIND_STRAY        = 5'd20;
	localparam logic [KIND_W-1:0] KIND_NONE         = 5'd0;

	// status bytes
	localparam logic [BYTE_W-1:0] ST_DATA_LIMIT  = 8'h80;
	localparam logic [BYTE_W-1:0] ST_SYSEX       = 8'hF0;
	localparam logic [BYTE_W-1:0] ST_QUARTER     = 8'hF1;
	localparam logic [BYTE_W-1:0] ST_SONG_POS    = 8'hF2;
	localparam logic [BYTE_W-1:0] ST_SONG_SEL    = 8'hF3;
	localparam logic [BYTE_W-1:0] ST_TUNE_REQ    = 8'hF6;
	localparam logic [BYTE_W-1:0] ST_EOX         = 8'hF7;
	localparam logic [BYTE_W-1:0] ST_CLOCK       = 8'hF8;
	localparam logic [BYTE_W-1:0] ST_START       = 8'hFA;
	localparam logic [BYTE_W-1:0] ST_CONTINUE    = 8'hFB;
	localparam logic [BYTE_W-1:0] ST_STOP        = 8'hFC;
	localparam logic [BYTE_W-1:0] ST_SENSE       = 8'hFE;
	localparam logic [BYTE_W-1:0] ST_RESET       = 8'hFF;

	localparam logic [3:0] HI_PITCH_BEND = 4'hE;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'b001,
		MODE_COLLECT = 3'b010,
		MODE_SYSEX   = 3'b100
	} mode_t;

	typedef struct packed {
		logic [KIND_W-1:0] event_kind;
		logic [CHAN_W-1:0] channel;
		logic [BYTE_W-1:0] data_first;
		logic [BYTE_W-1:0] data_second;
		logic [BEND_W-1:0] bend_value;
	} event_t;

	function automatic logic takes_two(input logic [BYTE_W-1:0] status);
		logic [3:0] hi;
		hi = status[7:4];
		return (status == ST_SONG_POS) || (hi == 4'h8) || (hi == 4'h9) ||
			(hi == 4'hA) || (hi == 4'hB) || (hi == HI_PITCH_BEND);
	endfunction

	function automatic logic [KIND_W-1:0] kind_of(input logic [BYTE_W-1:0] status);
		logic [KIND_W-1:0] k;
		if (status < ST_SYSEX) begin
			k = {2'b00, status[6:4]};
		end else begin
			case (status)
				ST_QUARTER:  k = KIND_QUARTER;
				ST_SONG_POS: k = KIND_SONG_POS;
				ST_SONG_SEL: k = KIND_SONG_SEL;
				ST_TUNE_REQ: k = KIND_TUNE_REQ;
				ST_CLOCK:    k = KIND_CLOCK;
				ST_START:    k = KIND_START;
				ST_CONTINUE: k = KIND_CONTINUE;
				ST_STOP:     k = KIND_STOP;
				ST_SENSE:    k = KIND_SENSE;
				ST_RESET:    k = KIND_RESET;
				default:     k = KIND_NONE;
			endcase
		end
		return k;
	endfunction

endpackage

// ===== sv/mbsp_if.sv =====
// Valid/ready channel interfaces: received bytes in, parsed events out.
// Depends on mbsp_pkg for field widths.
interface mbsp_byte_if;
	logic                      valid;
	logic                      ready;
	logic [mbsp_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mbsp_event_if;
	logic                      valid;
	logic                      ready;
	logic [mbsp_pkg::KIND_W-1:0] event_kind;
	logic [mbsp_pkg::CHAN_W-1:0] channel;
	logic [mbsp_pkg::BYTE_W-1:0] data_first;
	logic [mbsp_pkg::BYTE_W-1:0] data_second;
	logic [mbsp_pkg::BEND_W-1:0] bend_value;

	modport source (output valid, output event_kind, output channel, output data_first,
		output data_second, output bend_value, input ready);
	modport sink   (input valid, input event_kind, input channel, input data_first,
		input data_second, input bend_value, output ready);
endinterface

// ===== sv/mbsp_parse_core.sv =====
// Parser state and per-byte decode: one byte in, at most one event out.
// Depends on mbsp_pkg.
module mbsp_parse_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic [mbsp_pkg::BYTE_W-1:0] rx_byte,
	output logic                    emit,
	output mbsp_pkg::event_t        ev
);
	import mbsp_pkg::*;

	mode_t              mode_q, mode_n;
	logic [BYTE_W-1:0]  held_q, held_n;
	logic               pending_q, pending_n;
	logic [BYTE_W-1:0]  first_q, first_n;
	logic               two;
	logic [BYTE_W-1:0]  d1, d2;

	always_comb begin
		mode_n    = mode_q;
		held_n    = held_q;
		pending_n = pending_q;
		first_n   = first_q;
		emit      = 1'b0;
		ev        = '0;
		two       = takes_two(held_q);
		d1        = two ? first_q : rx_byte;
		d2        = two ? rx_byte : '0;
		unique case (mode_q)
			MODE_COLLECT: begin
				if (pending_q) begin
					// hold the first of two data bytes
					first_n   = rx_byte;
					pending_n = 1'b0;
				end else begin
					emit          = 1'b1;
					ev.event_kind = kind_of(held_q);
					ev.channel    = (held_q < ST_SYSEX) ? held_q[3:0] : '0;
					ev.data_first = d1;
					ev.data_second = d2;
					if (held_q[7:4] == HI_PITCH_BEND)
						ev.bend_value = {d2, 7'b0} | {7'b0, d1};
					mode_n = MODE_IDLE;
				end
			end
			MODE_SYSEX: begin
				emit = 1'b1;
				if (rx_byte == ST_EOX) begin
					ev.event_kind = KIND_SYSEX_END;
					mode_n = MODE_IDLE;
				end else begin
					ev.event_kind = KIND_SYSEX_DATA;
					ev.data_first = rx_byte;
				end
			end
			default: begin
				if (rx_byte < ST_DATA_LIMIT) begin
					emit          = 1'b1;
					ev.event_kind = KIND_STRAY;
					ev.data_first = rx_byte;
				end else if (rx_byte < ST_SYSEX || rx_byte == ST_QUARTER ||
						rx_byte == ST_SONG_POS || rx_byte == ST_SONG_SEL) begin
					held_n    = rx_byte;
					pending_n = takes_two(rx_byte);
					mode_n    = MODE_COLLECT;
				end else begin
					case (rx_byte) inside
						ST_SYSEX: begin
							emit          = 1'b1;
							ev.event_kind = KIND_SYSEX_START;
							mode_n        = MODE_SYSEX;
						end
						ST_TUNE_REQ, ST_CLOCK, ST_START, ST_CONTINUE,
						ST_STOP, ST_SENSE, ST_RESET: begin
							emit          = 1'b1;
							ev.event_kind = kind_of(rx_byte);
						end
						default: ; // drop undefined status and lone end of sysex
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			held_q    <= '0;
			pending_q <= 1'b0;
			first_q   <= '0;
		end else if (advance) begin
			mode_q    <= mode_n;
			held_q    <= held_n;
			pending_q <= pending_n;
			first_q   <= first_n;
		end
	end

	a_collect_done: assert property (@(posedge clk) disable iff (!arst_n)
		advance && mode_q == MODE_COLLECT && !pending_q |=> mode_q == MODE_IDLE)
		else $error("collect did not return to idle");
	a_bend_only: assert property (@(posedge clk) disable iff (!arst_n)
		emit && ev.event_kind != KIND_PITCH_BEND |-> ev.bend_value == '0)
		else $error("bend value on non pitch bend event");
	a_sysex_end: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_SYSEX && rx_byte == ST_EOX |-> emit && ev.event_kind == KIND_SYSEX_END)
		else $error("end of sysex not reported");
	a_pending_collect: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> mode_q == MODE_COLLECT)
		else $error("pending data byte outside collect");
endmodule

// ===== sv/mbsp_out_stage.sv =====
// Result register driving the event channel.
// Depends on mbsp_pkg and mbsp_event_if.
module mbsp_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  mbsp_pkg::event_t ev,
	output logic             free,
	mbsp_event_if.source     evt
);
	import mbsp_pkg::*;

	logic   valid_q;
	event_t ev_q;

	assign free = !valid_q || evt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (free)
			valid_q <= load;
	end

	always_ff @(posedge clk) begin
		if (free && load)
			ev_q <= ev;
	end

	assign evt.valid       = valid_q;
	assign evt.event_kind  = ev_q.event_kind;
	assign evt.channel     = ev_q.channel;
	assign evt.data_first  = ev_q.data_first;
	assign evt.data_second = ev_q.data_second;
	assign evt.bend_value  = ev_q.bend_value;
endmodule

// ===== sv/midi_byte_stream_parser_top.sv =====
// Top level of the MIDI byte stream parser: input register, parse core, result register.
// Depends on mbsp_pkg, mbsp_if, mbsp_parse_core and mbsp_out_stage.
//
// Usage:
//   rx  : one received MIDI byte per word (rx_byte), valid/ready.
//   evt : one parsed event per word (event_kind, channel, data_first,
//         data_second, bend_value), valid/ready.
// A byte taken at one clock edge sits in the input register,
// is decoded against the parser state and, if it completes an event,
// lands in the result register when the core advances. Bytes that
// only set up a message (status, first data byte, undefined status)
// produce no word.
// Throughput is one byte per cycle; the only limit is the result register,
// which holds one event until the receiver takes it.
// When the receiver stalls, a byte whose event cannot enter the full result
// register waits in the input register and rx.ready drops; bytes that yield
// no event still pass.
// Reset clears the parser to idle and empties both registers.
module midi_byte_stream_parser_top (
	input  logic         clk,
	input  logic         arst_n,
	mbsp_byte_if.sink    rx,
	mbsp_event_if.source evt
);
	import mbsp_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              emit;
	logic              free;
	logic              advance;
	event_t            ev;

	assign advance  = valid_s1 && (!emit || free);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (rx.ready)
			valid_s1 <= rx.valid;
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid)
			byte_s1 <= rx.rx_byte;
	end

	mbsp_parse_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.rx_byte (byte_s1),
		.emit    (emit),
		.ev      (ev)
	);

	mbsp_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && emit),
		.ev     (ev),
		.free   (free),
		.evt    (evt)
	);
endmodule
